/* src/sspt_pkg.sv */
// Shared types, constants and the key compare for the stable sorted pass table.
// Used by every module of the block; depends on nothing.
package sspt_pkg;

   localparam int CAPACITY    = 32;
   localparam int MAX_RESULTS = 32;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_LIST   = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_NONE = 2'd2;

   typedef struct packed {
      logic               action;
      logic [3:0]         entry_stage;
      logic signed [31:0] entry_order;
      logic [15:0]        tie_rank;
      logic [15:0]        pass_handle;
      logic [3:0]         query_stage;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] handle_out;
      logic        last;
      logic [5:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [3:0]         stage;
      logic signed [31:0] order;
      logic [15:0]        tie;
      logic [15:0]        handle;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic    vld;
      rsp_type rsp;
   } emit_type;

   // a sorts strictly before b: stage, then signed order, then tie rank
   function automatic logic key_less(entry_type a, entry_type b);
      logic lt;
      if (a.stage != b.stage) begin
         lt = (a.stage < b.stage);
      end else if (a.order != b.order) begin
         lt = (a.order < b.order);
      end else begin
         lt = (a.tie < b.tie);
      end
      return lt;
   endfunction

endpackage

/* src/sspt_entry_ram.sv */
// Entry store of the table: one write port, one registered read port.
// Depends on sspt_pkg for the entry and request types.
module sspt_entry_ram
   import sspt_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output entry_type   rd_data
);

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/sspt_rsp_reg.sv */
// Output register of the result channel; gives the sequencer slot_free from rsp_stall.
// Depends on sspt_pkg for the result types.
module sspt_rsp_reg
   import sspt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  emit_type emit,
   output logic     slot_free,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;

   assign slot_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (emit.vld) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.vld) begin
         data_ff <= emit.rsp;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* src/sspt_seq.sv */
// Sequencer: insert walk (shift up from the tail) and list scan over the entry store.
// Depends on sspt_pkg; drives sspt_entry_ram and sspt_rsp_reg.
module sspt_seq
   import sspt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output mem_req_type mem_req,
   input  entry_type   rd_data,
   input  logic        slot_free,
   output emit_type    emit
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_INS   = 3'd2;
   localparam logic [2:0] ST_PUT   = 3'd3;
   localparam logic [2:0] ST_FINAL = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   entry_type         new_ff, new_in;
   logic [3:0]        query_ff, query_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic [15:0]       pend_handle_ff, pend_handle_in;
   logic [RES_W-1:0]  nmatch_ff, nmatch_in;
   logic [1:0]        fin_status_ff, fin_status_in;
   logic [15:0]       fin_handle_ff, fin_handle_in;

   logic      accept;
   logic      match;
   logic      can_go;
   entry_type req_entry;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   assign req_entry.stage  = req_data.entry_stage;
   assign req_entry.order  = req_data.entry_order;
   assign req_entry.tie    = req_data.tie_rank;
   assign req_entry.handle = req_data.pass_handle;

   assign match  = (rd_data.stage == query_ff);
   // a second match pushes the held one out, which needs the output slot
   assign can_go = !(match && pend_ff) || slot_free;

   always_comb begin
      state_in       = state_ff;
      held_in        = held_ff;
      pos_in         = pos_ff;
      new_in         = new_ff;
      query_in       = query_ff;
      idx_in         = idx_ff;
      pend_in        = pend_ff;
      pend_handle_in = pend_handle_ff;
      nmatch_in      = nmatch_ff;
      fin_status_in  = fin_status_ff;
      fin_handle_in  = fin_handle_ff;
      mem_req        = '0;
      emit           = '0;
      emit.rsp.entry_count = 6'(held_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               new_in        = req_entry;
               query_in      = req_data.query_stage;
               pend_in       = 1'b0;
               nmatch_in     = '0;
               fin_handle_in = '0;
               if (req_data.action == ACT_LIST) begin
                  if (held_ff == '0) begin
                     fin_status_in = STATUS_NONE;
                     state_in      = ST_FINAL;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = '0;
                     idx_in          = CNT_W'(1);
                     state_in        = ST_SCAN;
                  end
               end else if (held_ff == CNT_W'(CAPACITY)) begin
                  fin_status_in = STATUS_FULL;
                  state_in      = ST_FINAL;
               end else if (held_ff == '0) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = '0;
                  mem_req.wr_data = req_entry;
                  held_in         = CNT_W'(1);
                  fin_status_in   = STATUS_OK;
                  state_in        = ST_FINAL;
               end else begin
                  pos_in          = ADDR_W'(held_ff);
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = ADDR_W'(held_ff - CNT_W'(1));
                  state_in        = ST_INS;
               end
            end
         end

         ST_INS: begin
            // reads pos-2 while writing pos: the two never hit the same entry
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            if (key_less(new_ff, rd_data)) begin
               mem_req.wr_data = rd_data;
               pos_in          = pos_ff - ADDR_W'(1);
               if (pos_ff == ADDR_W'(1)) begin
                  state_in = ST_PUT;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = pos_ff - ADDR_W'(2);
               end
            end else begin
               mem_req.wr_data = new_ff;
               held_in         = held_ff + CNT_W'(1);
               fin_status_in   = STATUS_OK;
               state_in        = ST_FINAL;
            end
         end

         ST_PUT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            mem_req.wr_data = new_ff;
            held_in         = held_ff + CNT_W'(1);
            fin_status_in   = STATUS_OK;
            state_in        = ST_FINAL;
         end

         ST_SCAN: begin
            if (can_go) begin
               if (match) begin
                  if (pend_ff) begin
                     emit.vld             = 1'b1;
                     emit.rsp.status      = STATUS_OK;
                     emit.rsp.handle_out  = pend_handle_ff;
                     emit.rsp.last        = 1'b0;
                  end
                  pend_in        = 1'b1;
                  pend_handle_in = rd_data.handle;
                  nmatch_in      = nmatch_ff + RES_W'(1);
               end
               if ((idx_ff == held_ff) ||
                   (match && (nmatch_ff + RES_W'(1) == RES_W'(MAX_RESULTS)))) begin
                  fin_status_in = pend_in ? STATUS_OK : STATUS_NONE;
                  fin_handle_in = pend_in ? pend_handle_in : 16'd0;
                  state_in      = ST_FINAL;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = ADDR_W'(idx_ff);
                  idx_in          = idx_ff + CNT_W'(1);
               end
            end
         end

         ST_FINAL: begin
            emit.vld            = slot_free;
            emit.rsp.status     = fin_status_ff;
            emit.rsp.handle_out = fin_handle_ff;
            emit.rsp.last       = 1'b1;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      new_ff         <= new_in;
      query_ff       <= query_in;
      idx_ff         <= idx_in;
      pend_handle_ff <= pend_handle_in;
      nmatch_ff      <= nmatch_in;
      fin_status_ff  <= fin_status_in;
      fin_handle_ff  <= fin_handle_in;
   end

endmodule

/* src/stable_sorted_pass_table_unit.sv */
// Top level of the stable sorted pass table: entry store, sequencer, output register.
// Depends on sspt_pkg, sspt_entry_ram, sspt_seq and sspt_rsp_reg.
//
// Keeps up to CAPACITY entries sorted by (stage, signed order, tie rank); equal keys stay
// in arrival order. One item is worked at a time; req_stall is high while it is in flight.
// An insert into a non-empty table shifts each entry with a larger key up one place from
// the tail and then writes the new one; into an empty table it writes at once. A list walks
// the held entries and gives one result per matching entry, the last one flagged, or a
// single none-found result. Both walk the entry store through its single read port, one
// entry per cycle unless a list scan waits for a free output slot. Inserting into a full
// table returns a full status and leaves the table as it was. No clearing pass after reset.
module stable_sorted_pass_table_unit
   import sspt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   mem_req_type mem_req;
   entry_type   rd_data;
   emit_type    emit;
   logic        slot_free;

   sspt_entry_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   sspt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .slot_free (slot_free),
      .emit      (emit)
   );

   sspt_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_FULL) |-> rsp_data.entry_count == 6'(CAPACITY))
      else $error("full status with a count other than capacity");

   a_more_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> rsp_data.status == STATUS_OK)
      else $error("non-final result without ok status");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while another is in flight");

   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK && rsp_data.status != STATUS_FULL)
         |-> (rsp_data.last && rsp_data.handle_out == 16'd0))
      else $error("none-found result not final or carries a handle");

endmodule
